// ===== rtl/core/cwbd_pkg.sv =====
// Shared constants, types and helper functions of the centre window balance detector.
package cwbd_pkg;

	localparam int unsigned DEF_MAX_WIDTH  = 4096;
	localparam int unsigned DEF_MAX_HEIGHT = 4096;
	localparam int unsigned RESET_WIDTH    = 640;
	localparam int unsigned RESET_HEIGHT   = 480;

	localparam int unsigned CFG_DATA_W  = 13;
	localparam int unsigned CFG_INDEX_W = 1;
	localparam int unsigned PIX_W       = 8;
	localparam int unsigned TALLY_W     = 18;
	localparam logic [TALLY_W-1:0] TALLY_MAX = '1;

	localparam int unsigned CALC_W  = 15;
	localparam int unsigned RECIP_W = 16;
	localparam logic [RECIP_W-1:0] RECIP_TEN = 16'd52429;
	localparam int unsigned SHIFT_TEN  = 19;
	localparam int unsigned SHIFT_FIVE = 18;

	localparam int unsigned LUMA_W = 22;
	localparam logic [LUMA_W-1:0] WEIGHT_RED   = 22'd4899;
	localparam logic [LUMA_W-1:0] WEIGHT_GREEN = 22'd9617;
	localparam logic [LUMA_W-1:0] WEIGHT_BLUE  = 22'd1868;
	localparam logic [LUMA_W-1:0] LUMA_ROUND   = 22'd8192;
	localparam logic [LUMA_W-1:0] LIT_LIMIT    = 22'd16384;

	localparam int unsigned SCALED_W = 23;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_FRAME_WIDTH  = 1'b0,
		REG_FRAME_HEIGHT = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic               any_lit;
		logic               window_lit;
		logic [TALLY_W-1:0] left_tally;
		logic [TALLY_W-1:0] right_tally;
	} frame_sum_t;

	function automatic logic [CALC_W-1:0] div_by_ten(input logic [CALC_W-1:0] x);
		logic [CALC_W+RECIP_W-1:0] p;
		p = (CALC_W+RECIP_W)'(x) * (CALC_W+RECIP_W)'(RECIP_TEN);
		return CALC_W'(p >> SHIFT_TEN);
	endfunction

	function automatic logic [CALC_W-1:0] div_by_five(input logic [CALC_W-1:0] x);
		logic [CALC_W+RECIP_W-1:0] p;
		p = (CALC_W+RECIP_W)'(x) * (CALC_W+RECIP_W)'(RECIP_TEN);
		return CALC_W'(p >> SHIFT_FIVE);
	endfunction

endpackage

// ===== rtl/core/center_window_balance_detector_unit.sv =====
// Top level of the centre window balance detector.
//
// Pixels arrive in raster order on the input channel (in_valid/in_ready) as blue, green and
// red bytes, with frame_end marking the last pixel of a frame. Each transfer is tested for a
// nonzero rounded gray value and updates the frame flags and the two centre window tallies.
// The pixel that carries frame_end produces one result transfer on the output channel
// (out_valid/out_ready); all other pixels produce none.
// Throughput is one pixel per cycle while in_ready is high. After its final pixel is transferred,
// a result passes through the pixel stage and the balance compare stage to the output register.
// The frame size registers are written through cfg_we, cfg_index and cfg_wdata only while
// the block is idle; the user must ensure this, as the block does not enforce it. The window
// geometry is recomputed at the write and holds from the next pixel on.
// Values above the size limits are clipped to them. Reset sets the frame size to 640 by 480
// and clears the raster position, flags, tallies and all pipeline valid flags.
// When the receiver stalls, the output register holds its result and one more result waits
// in the compare stage; pixels of the next frame keep flowing until a third frame end
// reaches the pixel stage, at which point in_ready drops until the output is taken.
module center_window_balance_detector_unit #(
	parameter int unsigned MAX_WIDTH  = cwbd_pkg::DEF_MAX_WIDTH,
	parameter int unsigned MAX_HEIGHT = cwbd_pkg::DEF_MAX_HEIGHT
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [cwbd_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [cwbd_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [cwbd_pkg::PIX_W-1:0]       blue,
	input  logic [cwbd_pkg::PIX_W-1:0]       green,
	input  logic [cwbd_pkg::PIX_W-1:0]       red,
	input  logic                             frame_end,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic                             target_found,
	output logic                             target_centered,
	output logic [cwbd_pkg::TALLY_W-1:0]     left_count,
	output logic [cwbd_pkg::TALLY_W-1:0]     right_count
);

	localparam int unsigned WLIM = (MAX_WIDTH > cwbd_pkg::RESET_WIDTH) ?
		MAX_WIDTH : cwbd_pkg::RESET_WIDTH;
	localparam int unsigned HLIM = (MAX_HEIGHT > cwbd_pkg::RESET_HEIGHT) ?
		MAX_HEIGHT : cwbd_pkg::RESET_HEIGHT;
	localparam int unsigned WDIM = $clog2(WLIM + 1);
	localparam int unsigned HDIM = $clog2(HLIM + 1);
	localparam int unsigned AREA_W = WDIM + HDIM;

	logic [WDIM-1:0]      frame_width, win_width, win_x;
	logic [HDIM-1:0]      win_height, win_y;
	logic [AREA_W-1:0]    area;
	cwbd_pkg::frame_sum_t sum;
	logic                 sum_valid, sum_ready;

	cwbd_geometry #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_geometry (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata),
		.frame_width (frame_width),
		.win_width   (win_width),
		.win_x       (win_x),
		.win_height  (win_height),
		.win_y       (win_y),
		.area        (area)
	);

	cwbd_pixel #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_pixel (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.blue        (blue),
		.green       (green),
		.red         (red),
		.frame_end   (frame_end),
		.frame_width (frame_width),
		.win_width   (win_width),
		.win_x       (win_x),
		.win_height  (win_height),
		.win_y       (win_y),
		.sum         (sum),
		.sum_valid   (sum_valid),
		.sum_ready   (sum_ready)
	);

	cwbd_result #(
		.AREA_W (AREA_W)
	) u_result (
		.clk             (clk),
		.arst_n          (arst_n),
		.sum             (sum),
		.sum_valid       (sum_valid),
		.sum_ready       (sum_ready),
		.area            (area),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.target_found    (target_found),
		.target_centered (target_centered),
		.left_count      (left_count),
		.right_count     (right_count)
	);

	// A centred frame must have had at least one lit pixel.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (!target_centered || target_found))
		else $error("centred result without any lit pixel");

	// Window tallies can only grow from lit pixels.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (left_count != '0 || right_count != '0)) |-> target_found)
		else $error("nonzero window tally without any lit pixel");

	// Input backpressure only arises from a stalled output.
	assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (out_valid && !out_ready))
		else $error("input stalled while output side is free");

endmodule

// ===== rtl/core/cwbd_geometry.sv =====
// Frame size registers and the centre window geometry derived from them.
module cwbd_geometry #(
	parameter int unsigned MAX_WIDTH  = cwbd_pkg::DEF_MAX_WIDTH,
	parameter int unsigned MAX_HEIGHT = cwbd_pkg::DEF_MAX_HEIGHT,
	localparam int unsigned WLIM = (MAX_WIDTH > cwbd_pkg::RESET_WIDTH) ?
		MAX_WIDTH : cwbd_pkg::RESET_WIDTH,
	localparam int unsigned HLIM = (MAX_HEIGHT > cwbd_pkg::RESET_HEIGHT) ?
		MAX_HEIGHT : cwbd_pkg::RESET_HEIGHT,
	localparam int unsigned WDIM = $clog2(WLIM + 1),
	localparam int unsigned HDIM = $clog2(HLIM + 1),
	localparam int unsigned AREA_W = WDIM + HDIM
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [cwbd_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [cwbd_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	output logic [WDIM-1:0]                  frame_width,
	output logic [WDIM-1:0]                  win_width,
	output logic [WDIM-1:0]                  win_x,
	output logic [HDIM-1:0]                  win_height,
	output logic [HDIM-1:0]                  win_y,
	output logic [AREA_W-1:0]                area
);

	localparam int unsigned RST_WW = cwbd_pkg::RESET_WIDTH / 10;
	localparam int unsigned RST_WH = cwbd_pkg::RESET_HEIGHT / 5;
	localparam int unsigned RST_WX = (cwbd_pkg::RESET_WIDTH - RST_WW) / 2;
	localparam int unsigned RST_WY = (cwbd_pkg::RESET_HEIGHT - RST_WH) / 2;

	logic [cwbd_pkg::CALC_W-1:0] wdata_ext;
	logic [cwbd_pkg::CALC_W-1:0] w_sat, w_div, w_off;
	logic [cwbd_pkg::CALC_W-1:0] h_sat, h_div, h_off;
	logic [WDIM-1:0] frame_width_q, win_width_q, win_x_q;
	logic [HDIM-1:0] win_height_q, win_y_q;
	logic [AREA_W-1:0] area_q;

	always_comb begin
		wdata_ext = cwbd_pkg::CALC_W'(cfg_wdata);
		w_sat = (wdata_ext > cwbd_pkg::CALC_W'(MAX_WIDTH)) ?
			cwbd_pkg::CALC_W'(MAX_WIDTH) : wdata_ext;
		h_sat = (wdata_ext > cwbd_pkg::CALC_W'(MAX_HEIGHT)) ?
			cwbd_pkg::CALC_W'(MAX_HEIGHT) : wdata_ext;
		w_div = cwbd_pkg::div_by_ten(w_sat);
		h_div = cwbd_pkg::div_by_five(h_sat);
		w_off = (w_sat - w_div) >> 1;
		h_off = (h_sat - h_div) >> 1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q <= WDIM'(cwbd_pkg::RESET_WIDTH);
			win_width_q   <= WDIM'(RST_WW);
			win_x_q       <= WDIM'(RST_WX);
			win_height_q  <= HDIM'(RST_WH);
			win_y_q       <= HDIM'(RST_WY);
		end else if (cfg_we) begin
			unique case (cwbd_pkg::cfg_reg_t'(cfg_index))
				cwbd_pkg::REG_FRAME_WIDTH: begin
					frame_width_q <= WDIM'(w_sat);
					win_width_q   <= WDIM'(w_div);
					win_x_q       <= WDIM'(w_off);
				end
				cwbd_pkg::REG_FRAME_HEIGHT: begin
					win_height_q <= HDIM'(h_div);
					win_y_q      <= HDIM'(h_off);
				end
				default: begin
				end
			endcase
		end
	end

	// The area is needed only at the end of a frame, so it is registered behind the window sizes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			area_q <= AREA_W'(RST_WW * RST_WH);
		end else begin
			area_q <= AREA_W'(win_width_q) * AREA_W'(win_height_q);
		end
	end

	assign frame_width = frame_width_q;
	assign win_width   = win_width_q;
	assign win_x       = win_x_q;
	assign win_height  = win_height_q;
	assign win_y       = win_y_q;
	assign area        = area_q;

endmodule

// ===== rtl/core/cwbd_pixel.sv =====
// Pixel input register, lit test, raster position tracking and frame tallies.
module cwbd_pixel #(
	parameter int unsigned MAX_WIDTH  = cwbd_pkg::DEF_MAX_WIDTH,
	parameter int unsigned MAX_HEIGHT = cwbd_pkg::DEF_MAX_HEIGHT,
	localparam int unsigned WLIM = (MAX_WIDTH > cwbd_pkg::RESET_WIDTH) ?
		MAX_WIDTH : cwbd_pkg::RESET_WIDTH,
	localparam int unsigned HLIM = (MAX_HEIGHT > cwbd_pkg::RESET_HEIGHT) ?
		MAX_HEIGHT : cwbd_pkg::RESET_HEIGHT,
	localparam int unsigned WDIM = $clog2(WLIM + 1),
	localparam int unsigned HDIM = $clog2(HLIM + 1)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [cwbd_pkg::PIX_W-1:0] blue,
	input  logic [cwbd_pkg::PIX_W-1:0] green,
	input  logic [cwbd_pkg::PIX_W-1:0] red,
	input  logic                       frame_end,
	input  logic [WDIM-1:0]            frame_width,
	input  logic [WDIM-1:0]            win_width,
	input  logic [WDIM-1:0]            win_x,
	input  logic [HDIM-1:0]            win_height,
	input  logic [HDIM-1:0]            win_y,
	output cwbd_pkg::frame_sum_t       sum,
	output logic                       sum_valid,
	input  logic                       sum_ready
);

	localparam int unsigned CW = $clog2(WLIM);
	localparam int unsigned RW = $clog2(MAX_HEIGHT);
	localparam logic [RW-1:0] ROW_LAST = RW'(MAX_HEIGHT - 1);

	logic                       valid_s1, end_s1, fire_s1;
	logic [cwbd_pkg::PIX_W-1:0] blue_s1, green_s1, red_s1;
	logic [CW-1:0]              col_q;
	logic [RW-1:0]              row_q;
	logic                       any_lit_q, window_lit_q;
	logic [cwbd_pkg::TALLY_W-1:0] left_q, right_q;

	logic [cwbd_pkg::LUMA_W-1:0] luma;
	logic                        lit, col_in, row_in, hit, to_left, to_right, row_wrap;
	logic [WDIM:0]               dx, col_next;
	logic [HDIM:0]               dy;
	logic [WDIM-1:0]             half, pair;
	cwbd_pkg::frame_sum_t        sum_next;

	assign fire_s1  = valid_s1 && (!end_s1 || sum_ready);
	assign in_ready = !valid_s1 || fire_s1;

	always_comb begin
		luma = cwbd_pkg::LUMA_W'(red_s1) * cwbd_pkg::WEIGHT_RED
			+ cwbd_pkg::LUMA_W'(green_s1) * cwbd_pkg::WEIGHT_GREEN
			+ cwbd_pkg::LUMA_W'(blue_s1) * cwbd_pkg::WEIGHT_BLUE
			+ cwbd_pkg::LUMA_ROUND;
		lit = luma >= cwbd_pkg::LIT_LIMIT;

		dx     = (WDIM+1)'(col_q) - (WDIM+1)'(win_x);
		dy     = (HDIM+1)'(row_q) - (HDIM+1)'(win_y);
		half   = win_width >> 1;
		pair   = {win_width[WDIM-1:1], 1'b0};
		col_in = !dx[WDIM] && (dx[WDIM-1:0] < win_width);
		row_in = !dy[HDIM] && (dy[HDIM-1:0] < win_height);
		hit    = lit && col_in && row_in;
		to_left  = hit && (dx[WDIM-1:0] < half);
		to_right = hit && !to_left && (dx[WDIM-1:0] < pair);

		sum_next.any_lit    = any_lit_q || lit;
		sum_next.window_lit = window_lit_q || hit;
		sum_next.left_tally = (to_left && left_q != cwbd_pkg::TALLY_MAX) ?
			left_q + 1'b1 : left_q;
		sum_next.right_tally = (to_right && right_q != cwbd_pkg::TALLY_MAX) ?
			right_q + 1'b1 : right_q;

		col_next = (WDIM+1)'(col_q) + 1'b1;
		row_wrap = col_next >= (WDIM+1)'(frame_width);
	end

	assign sum       = sum_next;
	assign sum_valid = fire_s1 && end_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			blue_s1  <= blue;
			green_s1 <= green;
			red_s1   <= red;
			end_s1   <= frame_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q        <= '0;
			row_q        <= '0;
			any_lit_q    <= 1'b0;
			window_lit_q <= 1'b0;
			left_q       <= '0;
			right_q      <= '0;
		end else if (fire_s1) begin
			if (end_s1) begin
				col_q        <= '0;
				row_q        <= '0;
				any_lit_q    <= 1'b0;
				window_lit_q <= 1'b0;
				left_q       <= '0;
				right_q      <= '0;
			end else begin
				any_lit_q    <= sum_next.any_lit;
				window_lit_q <= sum_next.window_lit;
				left_q       <= sum_next.left_tally;
				right_q      <= sum_next.right_tally;
				if (row_wrap) begin
					col_q <= '0;
					if (row_q != ROW_LAST) begin
						row_q <= row_q + 1'b1;
					end
				end else begin
					col_q <= CW'(col_next);
				end
			end
		end
	end

endmodule

// ===== rtl/core/cwbd_result.sv =====
// Frame summary register, balance test and the result output register.
module cwbd_result #(
	parameter int unsigned AREA_W = 26
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  cwbd_pkg::frame_sum_t              sum,
	input  logic                              sum_valid,
	output logic                              sum_ready,
	input  logic [AREA_W-1:0]                 area,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              target_found,
	output logic                              target_centered,
	output logic [cwbd_pkg::TALLY_W-1:0]      left_count,
	output logic [cwbd_pkg::TALLY_W-1:0]      right_count
);

	localparam int unsigned CMP_W = (AREA_W > cwbd_pkg::SCALED_W) ?
		AREA_W : cwbd_pkg::SCALED_W;

	cwbd_pkg::frame_sum_t          sum_s2;
	logic                          valid_s2, out_valid_q, out_take;
	logic [cwbd_pkg::TALLY_W-1:0]  diff;
	logic [CMP_W-1:0]              scaled;
	logic                          centred;
	logic                          found_q, centred_q;
	logic [cwbd_pkg::TALLY_W-1:0]  left_q, right_q;

	assign out_take  = !out_valid_q || out_ready;
	assign sum_ready = !valid_s2 || out_take;

	always_comb begin
		diff = (sum_s2.left_tally > sum_s2.right_tally) ?
			sum_s2.left_tally - sum_s2.right_tally :
			sum_s2.right_tally - sum_s2.left_tally;
		// Twenty times the imbalance, built from two shifts.
		scaled  = (CMP_W'(diff) << 4) + (CMP_W'(diff) << 2);
		centred = sum_s2.window_lit && (scaled < CMP_W'(area));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (sum_valid && sum_ready) begin
				valid_s2 <= 1'b1;
			end else if (out_take) begin
				valid_s2 <= 1'b0;
			end
			if (out_take) begin
				out_valid_q <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (sum_valid && sum_ready) begin
			sum_s2 <= sum;
		end
		if (out_take && valid_s2) begin
			found_q   <= sum_s2.any_lit;
			centred_q <= centred;
			left_q    <= sum_s2.left_tally;
			right_q   <= sum_s2.right_tally;
		end
	end

	assign out_valid       = out_valid_q;
	assign target_found    = found_q;
	assign target_centered = centred_q;
	assign left_count      = left_q;
	assign right_count     = right_q;

endmodule

// ===== verif/center_window_balance_detector_unit_test.sv =====
// Self-checking testbench for the centre window balance detector: directed and random pixel frames against a predictor.
module center_window_balance_detector_unit_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned STALL_LIMIT  = 2000;
	localparam int unsigned RANDOM_ITEMS = 800;

	typedef struct packed {
		logic [cwbd_pkg::PIX_W-1:0] blue;
		logic [cwbd_pkg::PIX_W-1:0] green;
		logic [cwbd_pkg::PIX_W-1:0] red;
		logic                       last;
	} pixel_t;

	typedef struct packed {
		logic                         found;
		logic                         centred;
		logic [cwbd_pkg::TALLY_W-1:0] left;
		logic [cwbd_pkg::TALLY_W-1:0] right;
	} frame_result_t;

	logic                             clk;
	logic                             arst_n;
	logic                             cfg_we;
	logic [cwbd_pkg::CFG_INDEX_W-1:0] cfg_index;
	logic [cwbd_pkg::CFG_DATA_W-1:0]  cfg_wdata;
	logic                             in_valid;
	logic                             in_ready;
	logic [cwbd_pkg::PIX_W-1:0]       blue;
	logic [cwbd_pkg::PIX_W-1:0]       green;
	logic [cwbd_pkg::PIX_W-1:0]       red;
	logic                             frame_end;
	logic                             out_valid;
	logic                             out_ready;
	logic                             target_found;
	logic                             target_centered;
	logic [cwbd_pkg::TALLY_W-1:0]     left_count;
	logic [cwbd_pkg::TALLY_W-1:0]     right_count;

	pixel_t        pixel_backlog[$];
	pixel_t        pixel_on_bus;
	frame_result_t pending_results[$];
	int unsigned   send_idle_pct;
	int unsigned   recv_idle_pct;
	int unsigned   fail_count;
	int unsigned   stall_cycles;

	int unsigned   size_width;
	int unsigned   size_height;
	int unsigned   pos_col;
	int unsigned   pos_row;
	logic          any_lit;
	logic          window_lit;
	int unsigned   left_tally;
	int unsigned   right_tally;

	center_window_balance_detector_unit uut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_wdata       (cfg_wdata),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.blue            (blue),
		.green           (green),
		.red             (red),
		.frame_end       (frame_end),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.target_found    (target_found),
		.target_centered (target_centered),
		.left_count      (left_count),
		.right_count     (right_count)
	);

	function automatic void log_failure(input string msg);
		fail_count++;
		if (fail_count <= 10) begin
			$display("%s", msg);
		end
	endfunction

	function automatic void clear_frame_state();
		pos_col     = 0;
		pos_row     = 0;
		any_lit     = 1'b0;
		window_lit  = 1'b0;
		left_tally  = 0;
		right_tally = 0;
	endfunction

	function automatic void set_frame_size(input cwbd_pkg::cfg_reg_t idx,
	                                       input logic [cwbd_pkg::CFG_DATA_W-1:0] value);
		if (idx == cwbd_pkg::REG_FRAME_WIDTH) begin
			size_width = (value > cwbd_pkg::DEF_MAX_WIDTH) ? cwbd_pkg::DEF_MAX_WIDTH : value;
		end else begin
			size_height = (value > cwbd_pkg::DEF_MAX_HEIGHT) ? cwbd_pkg::DEF_MAX_HEIGHT : value;
		end
	endfunction

	function automatic int unsigned bump_tally(input int unsigned tally);
		return (tally >= cwbd_pkg::TALLY_MAX) ? cwbd_pkg::TALLY_MAX : tally + 1;
	endfunction

	function automatic void track_pixel(input pixel_t px);
		int unsigned   win_w;
		int unsigned   win_h;
		int unsigned   win_x;
		int unsigned   win_y;
		int unsigned   half;
		int unsigned   offset;
		int unsigned   diff;
		frame_result_t res;
		win_w = size_width / 10;
		win_h = size_height / 5;
		win_x = (size_width - win_w) / 2;
		win_y = (size_height - win_h) / 2;
		half  = win_w / 2;
		if (4899 * px.red + 9617 * px.green + 1868 * px.blue + 8192 >= 16384) begin
			any_lit = 1'b1;
			if (pos_row >= win_y && pos_row < win_y + win_h &&
			    pos_col >= win_x && pos_col < win_x + win_w) begin
				offset     = pos_col - win_x;
				window_lit = 1'b1;
				if (offset < half) begin
					left_tally = bump_tally(left_tally);
				end else if (offset < 2 * half) begin
					right_tally = bump_tally(right_tally);
				end
			end
		end
		if (px.last) begin
			diff        = (left_tally > right_tally) ? left_tally - right_tally
			                                         : right_tally - left_tally;
			res.found   = any_lit;
			res.centred = window_lit && (20 * diff < win_w * win_h);
			res.left    = left_tally[cwbd_pkg::TALLY_W-1:0];
			res.right   = right_tally[cwbd_pkg::TALLY_W-1:0];
			pending_results.push_back(res);
			clear_frame_state();
		end else if (pos_col + 1 >= size_width) begin
			pos_col = 0;
			if (pos_row + 1 < cwbd_pkg::DEF_MAX_HEIGHT) begin
				pos_row++;
			end
		end else begin
			pos_col++;
		end
	endfunction

	function automatic void push_pixel(input logic [cwbd_pkg::PIX_W-1:0] b,
	                                   input logic [cwbd_pkg::PIX_W-1:0] g,
	                                   input logic [cwbd_pkg::PIX_W-1:0] r, input logic last);
		pixel_t px;
		px.blue  = b;
		px.green = g;
		px.red   = r;
		px.last  = last;
		pixel_backlog.push_back(px);
	endfunction

	function automatic void push_random_pixel(input int unsigned dark_pct, input logic last);
		if ($urandom_range(99) >= dark_pct) begin
			push_pixel(cwbd_pkg::PIX_W'($urandom_range(255)), cwbd_pkg::PIX_W'($urandom_range(255)),
			           cwbd_pkg::PIX_W'($urandom_range(255)), last);
		end else if (dark_pct == 100 || $urandom_range(1) == 0) begin
			push_pixel(8'd0, 8'd0, 8'd0, last);
		end else begin
			push_pixel(cwbd_pkg::PIX_W'($urandom_range(5)), 8'd0,
			           cwbd_pkg::PIX_W'($urandom_range(1)), last);
		end
	endfunction

	task automatic write_reg(input cwbd_pkg::cfg_reg_t idx,
	                         input logic [cwbd_pkg::CFG_DATA_W-1:0] value);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		set_frame_size(idx, value);
	endtask

	task automatic wait_for_idle();
		while (pixel_backlog.size() > 0 || in_valid || pending_results.size() > 0) begin
			@(posedge clk);
		end
		repeat (4) @(posedge clk);
	endtask

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin : pixel_driver
		logic next_valid;
		next_valid = in_valid;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				track_pixel(pixel_on_bus);
				next_valid = 1'b0;
			end
			if (!next_valid && pixel_backlog.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				pixel_on_bus = pixel_backlog.pop_front();
				blue       <= pixel_on_bus.blue;
				green      <= pixel_on_bus.green;
				red        <= pixel_on_bus.red;
				frame_end  <= pixel_on_bus.last;
				next_valid = 1'b1;
			end
		end
		in_valid <= next_valid;
	end

	always @(posedge clk) begin : result_monitor
		frame_result_t got;
		frame_result_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				got.found   = target_found;
				got.centred = target_centered;
				got.left    = left_count;
				got.right   = right_count;
				if (pending_results.size() == 0) begin
					log_failure($sformatf("unexpected result: found=%0d centred=%0d left=%0d right=%0d",
					                      got.found, got.centred, got.left, got.right));
				end else begin
					want = pending_results.pop_front();
					if (got !== want) begin
						log_failure($sformatf({"result mismatch: expected found=%0d centred=%0d ",
						                       "left=%0d right=%0d, got found=%0d centred=%0d ",
						                       "left=%0d right=%0d"},
						                      want.found, want.centred, want.left, want.right,
						                      got.found, got.centred, got.left, got.right));
					end
				end
			end
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				stall_cycles = 0;
			end else begin
				stall_cycles++;
			end
			if (stall_cycles >= STALL_LIMIT) begin
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	initial begin : stimulus
		int unsigned random_items;
		int unsigned w;
		int unsigned h;
		int unsigned area;
		int unsigned len;
		int unsigned dark;
		int unsigned frames;
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = cwbd_pkg::REG_FRAME_WIDTH;
		cfg_wdata     = '0;
		in_valid      = 1'b0;
		blue          = '0;
		green         = '0;
		red           = '0;
		frame_end     = 1'b0;
		out_ready     = 1'b0;
		fail_count    = 0;
		stall_cycles  = 0;
		send_idle_pct = 29;
		recv_idle_pct = 74;
		random_items  = 0;
		size_width    = cwbd_pkg::RESET_WIDTH;
		size_height   = cwbd_pkg::RESET_HEIGHT;
		clear_frame_state();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Channel extremes and pixels either side of the lit threshold, in frames of one or two pixels.
		push_pixel(8'd0, 8'd0, 8'd0, 1'b1);
		push_pixel(8'd255, 8'd255, 8'd255, 1'b0);
		push_pixel(8'd0, 8'd0, 8'd0, 1'b1);
		push_pixel(8'd0, 8'd1, 8'd0, 1'b1);
		push_pixel(8'd0, 8'd0, 8'd1, 1'b1);
		push_pixel(8'd2, 8'd0, 8'd1, 1'b1);
		push_pixel(8'd1, 8'd0, 8'd1, 1'b1);
		push_pixel(8'd5, 8'd0, 8'd0, 1'b1);
		push_pixel(8'd4, 8'd0, 8'd0, 1'b1);
		push_pixel(8'd255, 8'd0, 8'd0, 1'b1);
		push_pixel(8'd0, 8'd255, 8'd0, 1'b0);
		push_pixel(8'd0, 8'd0, 8'd255, 1'b1);
		push_pixel(8'd0, 8'd0, 8'd0, 1'b0);
		push_pixel(8'd0, 8'd0, 8'd0, 1'b1);
		wait_for_idle();

		for (int phase = 0; random_items < RANDOM_ITEMS; phase++) begin
			case (phase)
				0: begin w = 20; h = 5; end
				1: begin w = 4096; h = 4096; end
				2: begin w = 8191; h = 8191; end
				3: begin w = 0; h = 0; end
				default: begin
					case ($urandom_range(9))
						0: begin w = $urandom_range(19); h = $urandom_range(10); end
						1: begin w = $urandom_range(4000, 8191); h = $urandom_range(4000, 8191); end
						2: begin w = $urandom_range(41, 8191); h = $urandom_range(5, 12); end
						default: begin w = $urandom_range(20, 40); h = $urandom_range(5, 10); end
					endcase
				end
			endcase
			if (random_items < RANDOM_ITEMS / 3) begin
				send_idle_pct = 29;
				recv_idle_pct = 74;
			end else if (random_items < 2 * RANDOM_ITEMS / 3) begin
				send_idle_pct = 74;
				recv_idle_pct = 29;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			write_reg(cwbd_pkg::REG_FRAME_WIDTH, cwbd_pkg::CFG_DATA_W'(w));
			write_reg(cwbd_pkg::REG_FRAME_HEIGHT, cwbd_pkg::CFG_DATA_W'(h));

			area   = w * h;
			frames = $urandom_range(2, 5);
			repeat (frames) begin
				if (random_items < RANDOM_ITEMS) begin
					case ($urandom_range(3))
						0: dark = 0;
						1: dark = 60;
						2: dark = 95;
						default: dark = 100;
					endcase
					if (area > 0 && area <= 600 && $urandom_range(9) < 6) begin
						len = area;
					end else if (area > 0 && area <= 600) begin
						len = $urandom_range(1, area + w);
					end else begin
						len = $urandom_range(1, 60);
					end
					for (int i = 0; i < len; i++) begin
						push_random_pixel(dark, i == len - 1);
					end
					random_items += len;
				end
			end
			// Sometimes leave a frame open so that the next size change lands mid-frame.
			if ($urandom_range(9) < 3) begin
				len = $urandom_range(1, 30);
				repeat (len) push_random_pixel(50, 1'b0);
				random_items += len;
			end
			wait_for_idle();
		end

		repeat (8) @(posedge clk);
		if (pending_results.size() > 0) begin
			log_failure($sformatf("%0d results never arrived", pending_results.size()));
		end
		if (fail_count == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/core/cwbd_pkg.sv
rtl/core/cwbd_geometry.sv
rtl/core/cwbd_pixel.sv
rtl/core/cwbd_result.sv
rtl/core/center_window_balance_detector_unit.sv
verif/center_window_balance_detector_unit_test.sv
